// ----- rtl/frame_downscale_history_stack_assert.svh -----
// Assertion macros used by the downscaler RTL.
`ifndef FRAME_DOWNSCALE_HISTORY_STACK_ASSERT_SVH
`define FRAME_DOWNSCALE_HISTORY_STACK_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define FDHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define FDHS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fdhs_pkg.sv -----
// Types and constants of the frame downscaler with frame history.
package fdhs_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SRC_ROWS = 2'd0,
        CFG_SRC_COLS = 2'd1,
        CFG_DST_ROWS = 2'd2,
        CFG_DST_COLS = 2'd3
    } t_cfg_index;

    // Register reset values.
    localparam logic [8:0] SRC_ROWS_RST = 9'd210;
    localparam logic [8:0] SRC_COLS_RST = 9'd160;
    localparam logic [7:0] DST_ROWS_RST = 8'd84;
    localparam logic [7:0] DST_COLS_RST = 8'd84;

    // Size limits.
    localparam logic [8:0] SRC_ROWS_MAX = 9'd256;
    localparam logic [7:0] DST_MAX      = 8'd128;

    // Item after position tracking: carries what the averaging stage needs.
    typedef struct packed {
        logic [6:0] row;
        logic [6:0] col;
        logic       frame_done;
        logic       row_same;
        logic       col_same;
        logic [7:0] pix;
        logic [7:0] last_pix;
        logic [7:0] dst_cols;
    } t_b_stage;

    // Item after averaging: waits for its history entry.
    typedef struct packed {
        logic [6:0] row;
        logic [6:0] col;
        logic       frame_done;
        logic [7:0] newest;
    } t_c_stage;

endpackage

// ----- rtl/frame_downscale_history_stack.sv -----
// Frame downscaler: 2x2 average of source pixels with a per-pixel frame history.
// Pixels are registered after position tracking, after averaging and at the output.
// Throughput: one pixel per cycle unless stalled; one history read and write a cycle.
// Reset: synchronous, active low; sizes return to 210x160 -> 84x84, counters to zero.
// After reset the history memory is cleared, one entry a cycle, with o_stall high,
// over all MAX_TARGET_PIXELS entries; configuration writes are taken during that time.
module frame_downscale_history_stack #(
    parameter int MAX_SOURCE_COLS   = 256,
    parameter int MAX_TARGET_PIXELS = 8192,
    parameter int STACK_FRAMES      = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_pixel,
    input  logic       i_start_of_frame,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_out_row,
    output logic [6:0] o_out_col,
    output logic [7:0] o_newest_value,
    output logic [7:0] o_previous_value,
    output logic [7:0] o_older_value,
    output logic [7:0] o_oldest_value,
    output logic       o_frame_done,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);

    localparam int CW     = (MAX_SOURCE_COLS > 2) ? $clog2(MAX_SOURCE_COLS) : 1;
    localparam int CXW    = ((CW > 9) ? CW : 9) + 1;
    localparam int AW     = ((CW + 8) > 17) ? (CW + 8) : 17;
    localparam int KW     = $clog2(MAX_TARGET_PIXELS);
    localparam int HW     = 8 * (STACK_FRAMES - 1);
    localparam int RDEPTH = 2 ** (CW + 1);
    localparam int DC_CAP = (MAX_TARGET_PIXELS < 128) ? MAX_TARGET_PIXELS : 128;
    localparam logic [8:0]     DC_CAP_V = 9'(DC_CAP);
    localparam logic [CXW-1:0] MSC_V    = CXW'(MAX_SOURCE_COLS);
    localparam logic [16:0]    MTP_V    = 17'(MAX_TARGET_PIXELS);
    localparam logic [KW-1:0]  K_LAST   = KW'(MAX_TARGET_PIXELS - 1);

    // Configuration registers.
    logic [8:0] r_src_rows, r_src_cols;
    logic [7:0] r_dst_rows, r_dst_cols;

    // Position state.
    logic [7:0]    r_row_cnt, n_row_cnt;
    logic [CW-1:0] r_col_cnt, n_col_cnt;
    logic [7:0]    r_tri, n_tri, r_tci, n_tci;
    logic [15:0]   r_racc, n_racc, r_cacc, n_cacc;
    logic          r_bank, n_bank;
    logic [7:0]    r_last_pix;

    // Pipeline registers.
    logic                 r_b_valid, r_c_valid, r_out_valid;
    fdhs_pkg::t_b_stage   r_b;
    fdhs_pkg::t_c_stage   r_c;
    logic [7:0]           r_prev_cf, r_prev_c;
    logic [KW-1:0]        r_c_k;
    logic [HW-1:0]        r_hist_rd, r_fwd_data;
    logic                 r_fwd_hit;
    logic [6:0]           r_out_row, r_out_col;
    logic [7:0]           r_out_new, r_out_prev, r_out_older, r_out_oldest;
    logic                 r_out_done;

    // History clearing pass.
    logic          r_clr_busy;
    logic [KW-1:0] r_clr_addr;

    // Memories.
    logic [7:0]    r_row_mem  [RDEPTH];
    logic [HW-1:0] r_hist_mem [MAX_TARGET_PIXELS];

    // Combinational signals.
    logic          w_en, w_in_acc;
    logic [8:0]    w_sr, w_sc;
    logic [CXW-1:0] w_sc_ext;
    logic [7:0]    w_dc, w_dr, w_lim_c, w_lim_r, w_q;
    logic [7:0]    w_qtab [128];
    logic [7:0]    w_r, w_tri, w_tci;
    logic [CW-1:0] w_c, w_cf;
    logic [15:0]   w_racc, w_cacc;
    logic [16:0]   w_r_dr;
    logic [AW-1:0] w_c_dc;
    logic          w_row_hit, w_col_hit, w_hit, w_row_same, w_col_same;
    logic          w_row_end, w_frame_end, w_frame_done;
    logic [7:0]    w_v_ff, w_v_fc, w_v_cf;
    logic [9:0]    w_sum;
    logic [16:0]   w_k_full;
    logic [KW-1:0] w_k;
    logic [HW-1:0] w_hist_cur, w_hist_new;
    logic          w_hist_we;

    // Handshake: the pipeline moves whenever the output register can take a result.
    assign w_en     = !r_out_valid || !i_stall;
    assign o_stall  = r_clr_busy || !w_en;
    assign w_in_acc = i_valid && !o_stall;

    // Largest row count that fits the target store for each column count.
    for (genvar g = 0; g < 128; g++) begin : g_qtab
        localparam int Q = MAX_TARGET_PIXELS / (g + 1);
        assign w_qtab[g] = (Q > 128) ? fdhs_pkg::DST_MAX : 8'(Q);
    end

    // Effective frame sizes after clamping.
    always_comb begin
        w_sc_ext = CXW'(r_src_cols);
        if (r_src_rows == 9'd0) begin
            w_sr = 9'd1;
        end else if (r_src_rows > fdhs_pkg::SRC_ROWS_MAX) begin
            w_sr = fdhs_pkg::SRC_ROWS_MAX;
        end else begin
            w_sr = r_src_rows;
        end
        if (r_src_cols == 9'd0) begin
            w_sc = 9'd1;
        end else if (w_sc_ext > MSC_V) begin
            w_sc = MSC_V[8:0];
        end else begin
            w_sc = r_src_cols;
        end
        w_lim_c = (w_sc > DC_CAP_V) ? DC_CAP_V[7:0] : w_sc[7:0];
        if (r_dst_cols == 8'd0) begin
            w_dc = 8'd1;
        end else if (r_dst_cols > w_lim_c) begin
            w_dc = w_lim_c;
        end else begin
            w_dc = r_dst_cols;
        end
        w_q     = w_qtab[7'(w_dc - 8'd1)];
        w_lim_r = (w_sr > 9'(fdhs_pkg::DST_MAX)) ? fdhs_pkg::DST_MAX : w_sr[7:0];
        if (w_q < w_lim_r) begin
            w_lim_r = w_q;
        end
        if (w_lim_r == 8'd0) begin
            w_lim_r = 8'd1;
        end
        if (r_dst_rows == 8'd0) begin
            w_dr = 8'd1;
        end else if (r_dst_rows > w_lim_r) begin
            w_dr = w_lim_r;
        end else begin
            w_dr = r_dst_rows;
        end
    end

    // Position tracking for the incoming pixel; start of frame restarts all counters.
    always_comb begin
        w_r    = i_start_of_frame ? 8'd0 : r_row_cnt;
        w_c    = i_start_of_frame ? '0 : r_col_cnt;
        w_tri  = i_start_of_frame ? 8'd0 : r_tri;
        w_tci  = i_start_of_frame ? 8'd0 : r_tci;
        w_racc = i_start_of_frame ? 16'd0 : r_racc;
        w_cacc = i_start_of_frame ? 16'd0 : r_cacc;

        w_r_dr = 17'(w_r) * 17'(w_dr);
        w_c_dc = AW'(w_c) * AW'(w_dc);

        w_row_hit  = (w_tri < w_dr) && (w_r_dr >= 17'(w_racc));
        w_col_hit  = (w_tci < w_dc) && (w_c_dc >= AW'(w_cacc));
        w_hit      = w_row_hit && w_col_hit;
        w_row_same = (w_r_dr == 17'(w_racc));
        w_col_same = (w_c_dc == AW'(w_cacc));
        w_cf       = w_col_same ? w_c : w_c - CW'(1);
        w_frame_done = (w_tri + 8'd1 == w_dr) && (w_tci + 8'd1 == w_dc);

        w_row_end   = (CXW'(w_c) + CXW'(1)) >= CXW'(w_sc);
        w_frame_end = (9'(w_r) + 9'd1) >= w_sr;

        n_tci  = w_col_hit ? w_tci + 8'd1 : w_tci;
        n_cacc = w_col_hit ? w_cacc + 16'(w_sc) : w_cacc;
        n_col_cnt = w_c + CW'(1);
        n_row_cnt = w_r;
        n_tri  = w_tri;
        n_racc = w_racc;
        n_bank = r_bank;
        if (w_row_end) begin
            n_bank    = !r_bank;
            n_col_cnt = '0;
            n_tci     = 8'd0;
            n_cacc    = 16'd0;
            if (w_row_hit) begin
                n_tri  = w_tri + 8'd1;
                n_racc = w_racc + 16'(w_sr);
            end
            if (w_frame_end) begin
                n_row_cnt = 8'd0;
                n_tri     = 8'd0;
                n_racc    = 16'd0;
            end else begin
                n_row_cnt = w_r + 8'd1;
            end
        end
    end

    // Averaging stage: the corners come from the previous row bank, the last pixel
    // of this row and the pixel itself.
    always_comb begin
        w_v_ff = r_b.row_same ? (r_b.col_same ? r_b.pix : r_b.last_pix) : r_prev_cf;
        w_v_fc = r_b.row_same ? r_b.pix : r_prev_c;
        w_v_cf = r_b.col_same ? r_b.pix : r_b.last_pix;
        w_sum  = 10'(w_v_ff) + 10'(w_v_fc) + 10'(w_v_cf) + 10'(r_b.pix);
        w_k_full = 17'(r_b.row) * 17'(r_b.dst_cols) + 17'(r_b.col);
        w_k    = (w_k_full >= MTP_V) ? K_LAST : w_k_full[KW-1:0];
    end

    // History stage: a write from the item just ahead is forwarded, then shifted.
    assign w_hist_cur = r_fwd_hit ? r_fwd_data : r_hist_rd;
    assign w_hist_we  = w_en && r_c_valid;
    assign w_hist_new = (w_hist_cur << 8) | HW'(r_c.newest);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_rows <= fdhs_pkg::SRC_ROWS_RST;
            r_src_cols <= fdhs_pkg::SRC_COLS_RST;
            r_dst_rows <= fdhs_pkg::DST_ROWS_RST;
            r_dst_cols <= fdhs_pkg::DST_COLS_RST;
        end else if (i_cfg_we) begin
            unique case (fdhs_pkg::t_cfg_index'(i_cfg_index))
                fdhs_pkg::CFG_SRC_ROWS: r_src_rows <= i_cfg_data;
                fdhs_pkg::CFG_SRC_COLS: r_src_cols <= i_cfg_data;
                fdhs_pkg::CFG_DST_ROWS: r_dst_rows <= i_cfg_data[7:0];
                fdhs_pkg::CFG_DST_COLS: r_dst_cols <= i_cfg_data[7:0];
            endcase
        end
    end

    // Control state: counters, valid flags, forwarding flag and clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt   <= 8'd0;
            r_col_cnt   <= '0;
            r_tri       <= 8'd0;
            r_tci       <= 8'd0;
            r_racc      <= 16'd0;
            r_cacc      <= 16'd0;
            r_bank      <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            if (w_in_acc) begin
                r_row_cnt <= n_row_cnt;
                r_col_cnt <= n_col_cnt;
                r_tri     <= n_tri;
                r_tci     <= n_tci;
                r_racc    <= n_racc;
                r_cacc    <= n_cacc;
                r_bank    <= n_bank;
            end
            if (w_en) begin
                r_b_valid   <= w_in_acc && w_hit;
                r_c_valid   <= r_b_valid;
                r_out_valid <= r_c_valid;
                r_fwd_hit   <= w_hist_we && (r_c_k == w_k);
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + KW'(1);
                if (r_clr_addr == K_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // Payload registers along the pipeline.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_last_pix <= i_pixel;
        end
        if (w_en) begin
            r_b.row        <= w_tri[6:0];
            r_b.col        <= w_tci[6:0];
            r_b.frame_done <= w_frame_done;
            r_b.row_same   <= w_row_same;
            r_b.col_same   <= w_col_same;
            r_b.pix        <= i_pixel;
            r_b.last_pix   <= r_last_pix;
            r_b.dst_cols   <= w_dc;

            r_c.row        <= r_b.row;
            r_c.col        <= r_b.col;
            r_c.frame_done <= r_b.frame_done;
            r_c.newest     <= w_sum[9:2];
            r_c_k          <= w_k;
            r_fwd_data     <= w_hist_new;

            r_out_row    <= r_c.row;
            r_out_col    <= r_c.col;
            r_out_done   <= r_c.frame_done;
            r_out_new    <= r_c.newest;
            r_out_prev   <= w_hist_cur[7:0];
            r_out_older  <= 8'(w_hist_cur >> 8);
            r_out_oldest <= 8'(w_hist_cur >> 16);
        end
    end

    // Row store: two banks, the current row is written while the previous one is read.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_row_mem[{r_bank, w_c}] <= i_pixel;
        end
        if (w_en) begin
            r_prev_cf <= r_row_mem[{!r_bank, w_cf}];
            r_prev_c  <= r_row_mem[{!r_bank, w_c}];
        end
    end

    // History store: cleared after reset, then read one stage ahead of its write-back.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_hist_mem[r_clr_addr] <= '0;
        end else if (w_hist_we) begin
            r_hist_mem[r_c_k] <= w_hist_new;
        end
        if (w_en) begin
            r_hist_rd <= r_hist_mem[w_k];
        end
    end

    // Output ports.
    assign o_valid          = r_out_valid;
    assign o_out_row        = r_out_row;
    assign o_out_col        = r_out_col;
    assign o_newest_value   = r_out_new;
    assign o_previous_value = r_out_prev;
    assign o_older_value    = r_out_older;
    assign o_oldest_value   = r_out_oldest;
    assign o_frame_done     = r_out_done;

    // Checks on the pipeline and the history forwarding.
`include "frame_downscale_history_stack_assert.svh"
    `FDHS_ASSERT_IMP(a_clear_empty, i_clk, i_rst_n, r_clr_busy, !r_b_valid && !r_c_valid && !r_out_valid, "pipeline busy during history clear")
    `FDHS_ASSERT_NXT(a_fwd_source, i_clk, i_rst_n, w_en && !w_hist_we, !r_fwd_hit, "forwarded history without a write")
    `FDHS_ASSERT_NXT(a_b_to_c, i_clk, i_rst_n, w_en && r_b_valid, r_c_valid, "item lost between averaging and history")
    `FDHS_ASSERT_NXT(a_c_to_out, i_clk, i_rst_n, w_en && r_c_valid, r_out_valid, "item lost before the output register")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the frame downscaler with per-pixel frame history.
module testbench;

    localparam int unsigned MAX_SOURCE_COLS   = 256;
    localparam int unsigned MAX_TARGET_PIXELS = 8192;
    localparam int unsigned SOURCE_ROWS_MAX   = 256;
    localparam int unsigned TARGET_MAX        = 128;
    localparam int unsigned SETTLE_CYCLES     = 8;
    localparam int unsigned PIXEL_TARGET      = 1850;
    localparam int unsigned FRAME_CAP         = 120;

    // One downscaled pixel as it leaves the block.
    typedef struct packed {
        logic [6:0] row;
        logic [6:0] col;
        logic [7:0] newest;
        logic [7:0] previous;
        logic [7:0] older;
        logic [7:0] oldest;
        logic       frame_done;
    } t_scaled;

    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       i_valid          = 1'b0;
    logic [7:0] i_pixel          = 8'd0;
    logic       i_start_of_frame = 1'b0;
    logic       i_stall          = 1'b0;
    logic       i_cfg_we         = 1'b0;
    fdhs_pkg::t_cfg_index i_cfg_index = fdhs_pkg::CFG_SRC_ROWS;
    logic [8:0] i_cfg_data       = 9'd0;
    logic       o_stall;
    logic       o_valid;
    logic [6:0] o_out_row;
    logic [6:0] o_out_col;
    logic [7:0] o_newest_value;
    logic [7:0] o_previous_value;
    logic [7:0] o_older_value;
    logic [7:0] o_oldest_value;
    logic       o_frame_done;

    // Idling controls, set at the falling edge; the hold-off count runs down at the rising edge.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned stall_hold     = 0;

    int unsigned pixels_sent = 0;
    int unsigned mismatches  = 0;

    // Predictor state: sizes, position counters, line stores and frame history.
    logic [8:0]  cfg_src_rows = fdhs_pkg::SRC_ROWS_RST;
    logic [8:0]  cfg_src_cols = fdhs_pkg::SRC_COLS_RST;
    logic [7:0]  cfg_dst_rows = fdhs_pkg::DST_ROWS_RST;
    logic [7:0]  cfg_dst_cols = fdhs_pkg::DST_COLS_RST;
    logic [7:0]  row_count    = 8'd0;
    logic [7:0]  col_count    = 8'd0;
    logic [7:0]  dst_row      = 8'd0;
    logic [7:0]  dst_col      = 8'd0;
    logic [15:0] row_acc      = 16'd0;
    logic [15:0] col_acc      = 16'd0;
    bit   [7:0]  line_cur  [MAX_SOURCE_COLS];
    bit   [7:0]  line_prev [MAX_SOURCE_COLS];
    bit   [7:0]  history   [MAX_TARGET_PIXELS][3];

    t_scaled downscaled_due[$];

    frame_downscale_history_stack dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_pixel          (i_pixel),
        .i_start_of_frame (i_start_of_frame),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_newest_value   (o_newest_value),
        .o_previous_value (o_previous_value),
        .o_older_value    (o_older_value),
        .o_oldest_value   (o_oldest_value),
        .o_frame_done     (o_frame_done),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A size of zero means one; anything above the limit means the limit.
    function automatic int unsigned clamp_size(input int unsigned value,
                                               input int unsigned upper);
        if (value == 0) return 1;
        return (value > upper) ? upper : value;
    endfunction

    // Source pixel at a position: the arriving one, this line's store or the last line's.
    function automatic logic [7:0] stored_pixel(input int unsigned row, input int unsigned col,
                                                input int unsigned cur_row,
                                                input int unsigned cur_col,
                                                input logic [7:0] pix);
        if (row == cur_row) begin
            if (col == cur_col) return pix;
            return line_cur[col];
        end
        return line_prev[col];
    endfunction

    // Advances the position tracking by one source pixel and queues any downscaled pixel.
    task automatic downscale_pixel(input logic [7:0] pix, input logic sof);
        int unsigned sr, sc, dr, dc, lim, r, c, rf, cf, sum, k;
        bit row_hit, col_hit;
        t_scaled res;
        sr  = clamp_size(32'(cfg_src_rows), SOURCE_ROWS_MAX);
        sc  = clamp_size(32'(cfg_src_cols), MAX_SOURCE_COLS);
        lim = (sc < TARGET_MAX) ? sc : TARGET_MAX;
        dc  = clamp_size(32'(cfg_dst_cols), lim);
        lim = (sr < TARGET_MAX) ? sr : TARGET_MAX;
        if (MAX_TARGET_PIXELS / dc < lim) lim = MAX_TARGET_PIXELS / dc;
        if (lim < 1) lim = 1;
        dr  = clamp_size(32'(cfg_dst_rows), lim);

        if (sof) begin
            row_count = 8'd0;
            col_count = 8'd0;
            dst_row   = 8'd0;
            dst_col   = 8'd0;
            row_acc   = 16'd0;
            col_acc   = 16'd0;
        end
        r = 32'(row_count);
        c = 32'(col_count);
        line_cur[c] = pix;

        row_hit = (dst_row < dr) && (r * dr >= row_acc);
        col_hit = (dst_col < dc) && (c * dc >= col_acc);
        if (row_hit && col_hit) begin
            rf  = (row_acc == r * dr) ? r : r - 1;
            cf  = (col_acc == c * dc) ? c : c - 1;
            sum = 32'(stored_pixel(rf, cf, r, c, pix));
            sum += 32'(stored_pixel(rf, c, r, c, pix));
            sum += 32'(stored_pixel(r, cf, r, c, pix));
            sum += 32'(pix);
            k = dst_row * dc + dst_col;
            if (k >= MAX_TARGET_PIXELS) k = MAX_TARGET_PIXELS - 1;
            res.row        = dst_row[6:0];
            res.col        = dst_col[6:0];
            res.newest     = 8'(sum >> 2);
            res.previous   = history[k][0];
            res.older      = history[k][1];
            res.oldest     = history[k][2];
            res.frame_done = (dst_row + 1 == dr) && (dst_col + 1 == dc);
            history[k][2] = history[k][1];
            history[k][1] = history[k][0];
            history[k][0] = res.newest;
            downscaled_due = {downscaled_due, res};
        end

        if (col_hit) begin
            dst_col = 8'(dst_col + 1);
            col_acc = 16'(col_acc + sc);
        end
        if (c + 1 >= sc) begin
            // End of a source line: it becomes the line above for the next one.
            line_prev = line_cur;
            col_count = 8'd0;
            dst_col   = 8'd0;
            col_acc   = 16'd0;
            if (row_hit) begin
                dst_row = 8'(dst_row + 1);
                row_acc = 16'(row_acc + sr);
            end
            if (r + 1 >= sr) begin
                row_count = 8'd0;
                dst_row   = 8'd0;
                row_acc   = 16'd0;
            end else begin
                row_count = 8'(r + 1);
            end
        end else begin
            col_count = 8'(c + 1);
        end
    endtask

    // Reports one field that differs.
    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compares a result transfer with the oldest downscaled pixel still due.
    task automatic check_result();
        t_scaled want;
        if (downscaled_due.size() == 0) begin
            mismatches++;
            $display("%0t: result expected none, actual row %0d col %0d value %0d",
                     $time, o_out_row, o_out_col, o_newest_value);
            return;
        end
        want = downscaled_due.pop_front();
        compare_field("out_row", {1'b0, want.row}, {1'b0, o_out_row});
        compare_field("out_col", {1'b0, want.col}, {1'b0, o_out_col});
        compare_field("newest_value", want.newest, o_newest_value);
        compare_field("previous_value", want.previous, o_previous_value);
        compare_field("older_value", want.older, o_older_value);
        compare_field("oldest_value", want.oldest, o_oldest_value);
        compare_field("frame_done", {7'd0, want.frame_done}, {7'd0, o_frame_done});
    endtask

    // Watches register writes, input transfers and result transfers.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fdhs_pkg::CFG_SRC_ROWS: cfg_src_rows = i_cfg_data;
                    fdhs_pkg::CFG_SRC_COLS: cfg_src_cols = i_cfg_data;
                    fdhs_pkg::CFG_DST_ROWS: cfg_dst_rows = i_cfg_data[7:0];
                    fdhs_pkg::CFG_DST_COLS: cfg_dst_cols = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) downscale_pixel(i_pixel, i_start_of_frame);
            if (o_valid && !i_stall) check_result();
        end
    end

    // Receiver: a requested hold-off first, otherwise random stalls.
    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            i_stall <= 1'b1;
            stall_hold = stall_hold - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offers one pixel until it is taken, then idles at random.
    task automatic send_pixel(input logic [7:0] pix, input logic sof);
        i_valid          <= 1'b1;
        i_pixel          <= pix;
        i_start_of_frame <= sof;
        do @(posedge i_clk); while (o_stall);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        pixels_sent++;
    endtask

    // Sends a run of random pixels with the odd stray start of frame.
    task automatic send_frame(input int unsigned length, input logic sof_first);
        logic [7:0] pix;
        for (int unsigned n = 0; n < length; n++) begin
            case ($urandom_range(9))
                0:       pix = 8'h00;
                1:       pix = 8'hFF;
                default: pix = 8'($urandom_range(255));
            endcase
            send_pixel(pix, (n == 0) ? sof_first : ($urandom_range(149) == 0));
        end
    endtask

    // Stops sending and waits until every due pixel has arrived and the pipeline is empty.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (downscaled_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Changes the idling pattern away from the rising edge; only called while idle.
    task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct,
                              input int unsigned hold);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        stall_hold     = hold;
        @(posedge i_clk);
    endtask

    task automatic write_register(input fdhs_pkg::t_cfg_index idx, input logic [8:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic program_sizes(input logic [8:0] src_rows, input logic [8:0] src_cols,
                                 input logic [8:0] dst_rows, input logic [8:0] dst_cols);
        write_register(fdhs_pkg::CFG_SRC_ROWS, src_rows);
        write_register(fdhs_pkg::CFG_SRC_COLS, src_cols);
        write_register(fdhs_pkg::CFG_DST_ROWS, dst_rows);
        write_register(fdhs_pkg::CFG_DST_COLS, dst_cols);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly small source sizes, with zero, oversize and large values now and then.
    function automatic logic [8:0] pick_source_size();
        case ($urandom_range(19))
            0:       return 9'd0;
            1:       return 9'($urandom_range(511, 257));
            2:       return 9'($urandom_range(256, 13));
            default: return 9'($urandom_range(12, 1));
        endcase
    endfunction

    function automatic logic [8:0] pick_target_size();
        case ($urandom_range(9))
            0:       return 9'd0;
            1:       return 9'($urandom_range(511));
            2:       return 9'($urandom_range(128, 9));
            default: return 9'($urandom_range(8, 1));
        endcase
    endfunction

    // Reset sizes of 210x160 down to 84x84: a few pixels of the first line.
    task automatic test_reset_sizes();
        logic [7:0] values [6] = '{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE};
        foreach (values[i]) send_pixel(values[i], i == 0);
        wait_idle();
    endtask

    // 3x3 down to 2x2: corner averages across the line store, then a second frame
    // so that the history of the first one shows.
    task automatic test_small_frame();
        logic [7:0] values [13] = '{8'hFF, 8'h00, 8'hFF,
                                    8'h00, 8'hFF, 8'hFF,
                                    8'hFF, 8'hFF, 8'hFF,
                                    8'h10, 8'h20, 8'h30, 8'h40};
        program_sizes(9'd3, 9'd3, 9'd2, 9'd2);
        foreach (values[i]) send_pixel(values[i], i == 0 || i == 9);
        wait_idle();
    endtask

    // Out-of-range sizes: rows clamp to 256, columns to 1, the top bit of a target
    // size is dropped; after the single target pixel the frame gives nothing more.
    task automatic test_clamping();
        program_sizes(9'd511, 9'd0, 9'd256, 9'd255);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h7F, 1'b0);
        send_pixel(8'h80, 1'b0);
        wait_idle();
    endtask

    // Largest sizes over part of a frame, then the smallest, where every pixel is a result.
    task automatic test_size_extremes();
        set_idling(35, 35, 0);
        program_sizes(9'd256, 9'd256, 9'd128, 9'd128);
        send_frame(300, 1'b1);
        wait_idle();
        program_sizes(9'd1, 9'd1, 9'd1, 9'd1);
        send_frame(40, 1'b1);
        wait_idle();
    endtask

    // Receiver holds off for a long stretch while pixels keep coming, so the block
    // fills and stalls its input; then the sender waits for everything to drain.
    task automatic test_backpressure();
        set_idling(0, 0, 100);
        send_frame(150, 1'b1);
        wait_idle();
        send_frame(30, 1'b1);
        wait_idle();
    endtask

    // Random sizes and mostly whole frames, cycling through the idling patterns.
    task automatic test_random_frames();
        int unsigned phase, frames, len, sr, sc;
        logic [8:0] src_rows, src_cols;
        phase = 0;
        while (pixels_sent < PIXEL_TARGET) begin
            case (phase % 4)
                0: set_idling(0, 0, 0);
                1: set_idling(76, 0, 0);
                2: set_idling(0, 76, 0);
                default: set_idling(35, 35, 0);
            endcase
            src_rows = pick_source_size();
            src_cols = pick_source_size();
            program_sizes(src_rows, src_cols, pick_target_size(), pick_target_size());
            sr = clamp_size(32'(src_rows), SOURCE_ROWS_MAX);
            sc = clamp_size(32'(src_cols), MAX_SOURCE_COLS);
            frames = $urandom_range(5, 2);
            for (int unsigned f = 0; f < frames; f++) begin
                if (pixels_sent >= PIXEL_TARGET) break;
                len = sr * sc;
                if (len > FRAME_CAP) len = FRAME_CAP;
                // Now and then a frame is cut short.
                if ($urandom_range(7) == 0) len = $urandom_range(len, 1);
                // The first frame after a size change always restarts the position.
                send_frame(len, (f == 0) || ($urandom_range(3) != 0));
            end
            wait_idle();
            phase++;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_sizes();
        test_small_frame();
        test_clamping();
        test_size_extremes();
        test_backpressure();
        test_random_frames();
        wait_idle();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest passing run, including the history clear.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- frame_downscale_history_stack.f -----
+incdir+rtl
rtl/fdhs_pkg.sv
rtl/frame_downscale_history_stack.sv
test/testbench.sv
